// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the 3x3 inverse block.
// Each macro compiles away when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hw/rtl/inv3_pkg.sv
// Package for the 3x3 inverse block: widths, types, index tables.
// No dependencies.
package inv3_pkg;

    localparam int N_ENT      = 9;
    localparam int DATA_W     = 32;
    localparam int THR_W      = 31;
    localparam int PROD_W     = 64;
    localparam int DET_W      = 97;
    localparam int REM_W      = 98;
    localparam int QUO_W      = 33;
    localparam int DIV_STAGES = 34;
    localparam int DIV_LAT    = DIV_STAGES + 1;
    localparam int FRONT_LAT  = 8;
    localparam int PIPE_DEPTH = FRONT_LAT + DIV_LAT;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [REM_W-1:0]         rem_t;
    typedef logic [DET_W-1:0]         den_t;
    typedef logic [QUO_W-1:0]         quo_t;

    // cofactor c[i] = m[PA]*m[PB] - m[PC]*m[PD]
    localparam logic [3:0] COF_PA [N_ENT] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
    localparam logic [3:0] COF_PB [N_ENT] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
    localparam logic [3:0] COF_PC [N_ENT] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
    localparam logic [3:0] COF_PD [N_ENT] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

    // result entry (i,j) takes cofactor (j,i)
    localparam logic [3:0] ADJ_SRC [N_ENT] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

// File: hw/rtl/inv3_div_pipe.sv
// Nine-lane pipelined restoring divider, one quotient bit per stage after the first.
// Depends on inv3_pkg. Signs and clips each quotient to Q16.16.
module inv3_div_pipe
(
    input  logic                                clk,
    input  logic                                en,
    input  inv3_pkg::rem_t                      a_in   [inv3_pkg::N_ENT],
    input  inv3_pkg::den_t                      b_in,
    input  logic [inv3_pkg::N_ENT-1:0]          neg_in,
    output logic [inv3_pkg::DATA_W-1:0]         res    [inv3_pkg::N_ENT],
    output logic [inv3_pkg::N_ENT-1:0]          clip
);

    localparam int REM_W_X = inv3_pkg::REM_W + 33;

    inv3_pkg::rem_t  rem_reg  [inv3_pkg::DIV_STAGES][inv3_pkg::N_ENT];
    inv3_pkg::rem_t  rem_next [inv3_pkg::DIV_STAGES][inv3_pkg::N_ENT];
    inv3_pkg::quo_t  quo_reg  [inv3_pkg::DIV_STAGES][inv3_pkg::N_ENT];
    inv3_pkg::quo_t  quo_next [inv3_pkg::DIV_STAGES][inv3_pkg::N_ENT];
    logic [inv3_pkg::N_ENT-1:0] ovf_reg  [inv3_pkg::DIV_STAGES];
    logic [inv3_pkg::N_ENT-1:0] ovf_next;
    logic [inv3_pkg::N_ENT-1:0] neg_reg  [inv3_pkg::DIV_STAGES];
    inv3_pkg::den_t  den_reg  [inv3_pkg::DIV_STAGES];
    logic [inv3_pkg::DATA_W-1:0] res_reg  [inv3_pkg::N_ENT];
    logic [inv3_pkg::DATA_W-1:0] res_next [inv3_pkg::N_ENT];
    logic [inv3_pkg::N_ENT-1:0]  clip_reg;
    logic [inv3_pkg::N_ENT-1:0]  clip_next;

    // first stage: quotient of 2^33 or more clips at once
    // later stages: trial subtract of the shifted divisor, one bit each
    always_comb
    begin
        logic [REM_W_X-1:0] trial;
        for (int l = 0; l < inv3_pkg::N_ENT; l++)
        begin
            ovf_next[l]    = {33'd0, a_in[l]} >= ({34'd0, b_in} << inv3_pkg::QUO_W);
            rem_next[0][l] = a_in[l];
            quo_next[0][l] = '0;
        end
        for (int s = 1; s < inv3_pkg::DIV_STAGES; s++)
        begin
            for (int l = 0; l < inv3_pkg::N_ENT; l++)
            begin
                trial = {33'd0, rem_reg[s-1][l]}
                      - ({34'd0, den_reg[s-1]} << (inv3_pkg::DIV_STAGES - 1 - s));
                rem_next[s][l] = trial[REM_W_X-1] ? rem_reg[s-1][l]
                                                  : trial[inv3_pkg::REM_W-1:0];
                quo_next[s][l] = {quo_reg[s-1][l][inv3_pkg::QUO_W-2:0], ~trial[REM_W_X-1]};
            end
        end
    end

    // sign and clip
    always_comb
    begin
        inv3_pkg::quo_t q;
        logic           big;
        logic [inv3_pkg::QUO_W-1:0] nq;
        for (int l = 0; l < inv3_pkg::N_ENT; l++)
        begin
            q   = quo_reg[inv3_pkg::DIV_STAGES-1][l];
            nq  = -q;
            if (neg_reg[inv3_pkg::DIV_STAGES-1][l])
            begin
                big          = ovf_reg[inv3_pkg::DIV_STAGES-1][l] || (q > 33'h0_8000_0000);
                res_next[l]  = big ? inv3_pkg::SAT_NEG : nq[inv3_pkg::DATA_W-1:0];
            end
            else
            begin
                big          = ovf_reg[inv3_pkg::DIV_STAGES-1][l] || (q > 33'h0_7FFF_FFFF);
                res_next[l]  = big ? inv3_pkg::SAT_POS : q[inv3_pkg::DATA_W-1:0];
            end
            clip_next[l] = big;
        end
    end

    // stage registers, all moving on the shared enable
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= ovf_next;
            neg_reg[0] <= neg_in;
            den_reg[0] <= b_in;
            for (int s = 1; s < inv3_pkg::DIV_STAGES; s++)
            begin
                ovf_reg[s] <= ovf_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                den_reg[s] <= den_reg[s-1];
            end
            for (int s = 0; s < inv3_pkg::DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
            res_reg  <= res_next;
            clip_reg <= clip_next;
        end
    end

    assign res  = res_reg;
    assign clip = clip_reg;

endmodule

// File: hw/rtl/inverse_3x3_block_unit.sv
// Top level of the 3x3 block inverse (adjugate over determinant, Q16.16).
// Depends on inv3_pkg, inv3_div_pipe and assert_macros.svh.
//
// Takes one 3x3 block per cycle and returns its inverse; a stall on the
// output freezes the whole pipeline, so throughput is one word per cycle
// whenever the output side is not stalled. The front end has 8 stages
// (input register, products, cofactors, split 64x32 determinant products,
// terms, determinant sum, magnitudes, dividend setup); the divider resolves
// one quotient bit per bit stage (overflow check, 33 bit stages, sign and
// clip); an output select register follows. A block whose determinant
// magnitude is at or below singular_threshold (Q15.16) comes back unchanged
// with singular set. The cfg port writes the threshold and is always ready.
`include "assert_macros.svh"
module inverse_3x3_block_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [inv3_pkg::DATA_W-1:0]   m00,
    input  logic signed [inv3_pkg::DATA_W-1:0]   m01,
    input  logic signed [inv3_pkg::DATA_W-1:0]   m02,
    input  logic signed [inv3_pkg::DATA_W-1:0]   m10,
    input  logic signed [inv3_pkg::DATA_W-1:0]   m11,
    input  logic signed [inv3_pkg::DATA_W-1:0]   m12,
    input  logic signed [inv3_pkg::DATA_W-1:0]   m20,
    input  logic signed [inv3_pkg::DATA_W-1:0]   m21,
    input  logic signed [inv3_pkg::DATA_W-1:0]   m22,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [inv3_pkg::DATA_W-1:0]   r00,
    output logic signed [inv3_pkg::DATA_W-1:0]   r01,
    output logic signed [inv3_pkg::DATA_W-1:0]   r02,
    output logic signed [inv3_pkg::DATA_W-1:0]   r10,
    output logic signed [inv3_pkg::DATA_W-1:0]   r11,
    output logic signed [inv3_pkg::DATA_W-1:0]   r12,
    output logic signed [inv3_pkg::DATA_W-1:0]   r20,
    output logic signed [inv3_pkg::DATA_W-1:0]   r21,
    output logic signed [inv3_pkg::DATA_W-1:0]   r22,
    output logic                                 singular,
    output logic                                 saturated,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [inv3_pkg::THR_W-1:0]           singular_threshold
);

    localparam int SING_DEPTH = inv3_pkg::DIV_LAT + 1;

    logic                        en;
    inv3_pkg::data_t             m_in      [inv3_pkg::N_ENT];
    logic [inv3_pkg::THR_W-1:0]  thr_reg;
    logic [inv3_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic                        out_vld_reg;

    // payload lines and stage registers
    inv3_pkg::data_t             pm_reg    [inv3_pkg::PIPE_DEPTH][inv3_pkg::N_ENT];
    inv3_pkg::prod_t             prod_reg  [2*inv3_pkg::N_ENT];
    inv3_pkg::prod_t             prod_next [2*inv3_pkg::N_ENT];
    inv3_pkg::prod_t             cof_reg   [4][inv3_pkg::N_ENT];
    inv3_pkg::prod_t             cof_next  [inv3_pkg::N_ENT];
    logic signed [63:0]          dph_reg   [3];
    logic signed [63:0]          dph_next  [3];
    logic signed [64:0]          dpl_reg   [3];
    logic signed [64:0]          dpl_next  [3];
    logic signed [95:0]          term_reg  [3];
    logic signed [95:0]          term_next [3];
    logic signed [inv3_pkg::DET_W-1:0] det_reg;
    logic signed [inv3_pkg::DET_W-1:0] det_next;
    inv3_pkg::den_t              dmag_reg;
    inv3_pkg::den_t              dmag_next;
    logic                        dneg_reg;
    logic [inv3_pkg::PROD_W-1:0] cmag_reg  [inv3_pkg::N_ENT];
    logic [inv3_pkg::PROD_W-1:0] cmag_next [inv3_pkg::N_ENT];
    logic [inv3_pkg::N_ENT-1:0]  cneg_reg;
    inv3_pkg::rem_t              a_reg     [inv3_pkg::N_ENT];
    inv3_pkg::rem_t              a_next    [inv3_pkg::N_ENT];
    inv3_pkg::den_t              b_reg;
    logic [inv3_pkg::N_ENT-1:0]  rneg_reg;
    logic [inv3_pkg::N_ENT-1:0]  rneg_next;
    logic [SING_DEPTH-1:0]       sing_reg;
    logic                        sing_next;

    logic [inv3_pkg::DATA_W-1:0] div_res   [inv3_pkg::N_ENT];
    logic [inv3_pkg::N_ENT-1:0]  div_clip;
    logic [inv3_pkg::DATA_W-1:0] r_reg     [inv3_pkg::N_ENT];
    logic [inv3_pkg::DATA_W-1:0] r_next    [inv3_pkg::N_ENT];
    logic                        osing_reg;
    logic                        osat_reg;
    logic                        osat_next;

    // whole pipeline moves unless a finished word is held at the output
    assign en        = !(out_vld_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    assign m_in[0] = m00;
    assign m_in[1] = m01;
    assign m_in[2] = m02;
    assign m_in[3] = m10;
    assign m_in[4] = m11;
    assign m_in[5] = m12;
    assign m_in[6] = m20;
    assign m_in[7] = m21;
    assign m_in[8] = m22;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            thr_reg <= singular_threshold;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[inv3_pkg::PIPE_DEPTH-2:0], in_valid};
            out_vld_reg <= vld_reg[inv3_pkg::PIPE_DEPTH-1];
        end
    end

    // front end arithmetic
    always_comb
    begin
        // S1: the 18 cofactor products
        for (int i = 0; i < inv3_pkg::N_ENT; i++)
        begin
            prod_next[2*i]   = pm_reg[0][COF_A(i)] * pm_reg[0][COF_B(i)];
            prod_next[2*i+1] = pm_reg[0][COF_C(i)] * pm_reg[0][COF_D(i)];
        end
        // S2: cofactors
        for (int i = 0; i < inv3_pkg::N_ENT; i++)
        begin
            cof_next[i] = prod_reg[2*i] - prod_reg[2*i+1];
        end
        // S3: c*m split into upper and lower 32x32 products
        for (int i = 0; i < 3; i++)
        begin
            dph_next[i] = $signed(cof_reg[0][i][63:32]) * pm_reg[2][i];
            dpl_next[i] = $signed({1'b0, cof_reg[0][i][31:0]}) * pm_reg[2][i];
        end
        // S4: recombine each term
        for (int i = 0; i < 3; i++)
        begin
            term_next[i] = {dph_reg[i], 32'd0} + {{31{dpl_reg[i][64]}}, dpl_reg[i]};
        end
        // S5: determinant
        det_next = {term_reg[0][95], term_reg[0]} + {term_reg[1][95], term_reg[1]}
                 + {term_reg[2][95], term_reg[2]};
        // S6: magnitudes
        dmag_next = det_reg[inv3_pkg::DET_W-1] ? -det_reg : det_reg;
        for (int i = 0; i < inv3_pkg::N_ENT; i++)
        begin
            cmag_next[i] = cof_reg[3][i][63] ? -cof_reg[3][i] : cof_reg[3][i];
        end
        // S7: dividend 2|N| + |D|, singular test
        for (int l = 0; l < inv3_pkg::N_ENT; l++)
        begin
            a_next[l]    = {1'b0, cmag_reg[inv3_pkg::ADJ_SRC[l]], 33'd0} + {1'b0, dmag_reg};
            rneg_next[l] = cneg_reg[inv3_pkg::ADJ_SRC[l]] ^ dneg_reg;
        end
        sing_next = dmag_reg <= {34'd0, thr_reg, 32'd0};
    end

    function automatic logic [3:0] COF_A(input int i);
        COF_A = inv3_pkg::COF_PA[i];
    endfunction
    function automatic logic [3:0] COF_B(input int i);
        COF_B = inv3_pkg::COF_PB[i];
    endfunction
    function automatic logic [3:0] COF_C(input int i);
        COF_C = inv3_pkg::COF_PC[i];
    endfunction
    function automatic logic [3:0] COF_D(input int i);
        COF_D = inv3_pkg::COF_PD[i];
    endfunction

    // front end registers and pass-through lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pm_reg[0] <= m_in;
            for (int s = 1; s < inv3_pkg::PIPE_DEPTH; s++)
            begin
                pm_reg[s] <= pm_reg[s-1];
            end
            prod_reg   <= prod_next;
            cof_reg[0] <= cof_next;
            cof_reg[1] <= cof_reg[0];
            cof_reg[2] <= cof_reg[1];
            cof_reg[3] <= cof_reg[2];
            dph_reg    <= dph_next;
            dpl_reg    <= dpl_next;
            term_reg   <= term_next;
            det_reg    <= det_next;
            dmag_reg   <= dmag_next;
            dneg_reg   <= det_reg[inv3_pkg::DET_W-1];
            cmag_reg   <= cmag_next;
            for (int i = 0; i < inv3_pkg::N_ENT; i++)
            begin
                cneg_reg[i] <= cof_reg[3][i][63];
            end
            a_reg      <= a_next;
            b_reg      <= {dmag_reg[inv3_pkg::DET_W-2:0], 1'b0};
            rneg_reg   <= rneg_next;
            sing_reg   <= {sing_reg[SING_DEPTH-2:0], sing_next};
            r_reg      <= r_next;
            osing_reg  <= sing_reg[SING_DEPTH-1];
            osat_reg   <= osat_next;
        end
    end

    inv3_div_pipe u_div
    (
        .clk    (clk),
        .en     (en),
        .a_in   (a_reg),
        .b_in   (b_reg),
        .neg_in (rneg_reg),
        .res    (div_res),
        .clip   (div_clip)
    );

    // output select: pass the block through when singular
    always_comb
    begin
        for (int l = 0; l < inv3_pkg::N_ENT; l++)
        begin
            r_next[l] = sing_reg[SING_DEPTH-1] ? pm_reg[inv3_pkg::PIPE_DEPTH-1][l] : div_res[l];
        end
        osat_next = !sing_reg[SING_DEPTH-1] && (|div_clip);
    end

    assign out_valid = out_vld_reg;
    assign r00       = r_reg[0];
    assign r01       = r_reg[1];
    assign r02       = r_reg[2];
    assign r10       = r_reg[3];
    assign r11       = r_reg[4];
    assign r12       = r_reg[5];
    assign r20       = r_reg[6];
    assign r21       = r_reg[7];
    assign r22       = r_reg[8];
    assign singular  = osing_reg;
    assign saturated = osat_reg;

    // checks
    `ASSERT_IMPL(a_sing_no_sat, clk, rst_n, out_valid && singular, !saturated)
    `ASSERT_IMPL(a_sat_clipped, clk, rst_n, out_valid && saturated,
        r00 == inv3_pkg::SAT_POS || r00 == inv3_pkg::SAT_NEG
        || r01 == inv3_pkg::SAT_POS || r01 == inv3_pkg::SAT_NEG
        || r02 == inv3_pkg::SAT_POS || r02 == inv3_pkg::SAT_NEG
        || r10 == inv3_pkg::SAT_POS || r10 == inv3_pkg::SAT_NEG
        || r11 == inv3_pkg::SAT_POS || r11 == inv3_pkg::SAT_NEG
        || r12 == inv3_pkg::SAT_POS || r12 == inv3_pkg::SAT_NEG
        || r20 == inv3_pkg::SAT_POS || r20 == inv3_pkg::SAT_NEG
        || r21 == inv3_pkg::SAT_POS || r21 == inv3_pkg::SAT_NEG
        || r22 == inv3_pkg::SAT_POS || r22 == inv3_pkg::SAT_NEG)
    `ASSERT_NEXT(a_hold_last, clk, rst_n,
        vld_reg[inv3_pkg::PIPE_DEPTH-1] && out_vld_reg && out_stall,
        vld_reg[inv3_pkg::PIPE_DEPTH-1] && out_vld_reg)

endmodule

// File: sim/tb.sv
// Self-checking testbench for inverse_3x3_block_unit (3x3 Q16.16 block inverse).
// Depends on inv3_pkg and the block RTL; an inline scoreboard predicts every result word.
`timescale 1ns / 100ps

module tb;

    typedef struct {
        inv3_pkg::data_t e [inv3_pkg::N_ENT];
    } blk_t;

    typedef struct {
        inv3_pkg::data_t r [inv3_pkg::N_ENT];
        bit    singular;
        bit    saturated;
    } inv_res_t;

    // Scoreboard: predicts the inverse of each accepted block and checks outputs in order
    class inverse_scoreboard;
        inv_res_t          pending [$];
        logic [inv3_pkg::THR_W-1:0] threshold;
        int                errors;
        int                n_checked;
        int                n_singular;
        int                n_saturated;

        function new();
            threshold = '0;
            errors = 0;
            n_checked = 0;
            n_singular = 0;
            n_saturated = 0;
        endfunction

        // Adjugate over determinant, rounded half away from zero, clipped
        function inv_res_t invert(blk_t b);
            inv_res_t          res;
            logic signed [65:0] m [inv3_pkg::N_ENT];
            logic signed [65:0] c [inv3_pkg::N_ENT];
            logic signed [65:0] cf;
            logic signed [99:0] det;
            logic [131:0]      dmag, num, q, lim;
            logic [65:0]       cm;
            bit                dneg, neg;
            m = '{default: '0};
            for (int i = 0; i < inv3_pkg::N_ENT; i++)
                m[i] = b.e[i];
            c[0] = m[4] * m[8] - m[5] * m[7];
            c[1] = m[5] * m[6] - m[3] * m[8];
            c[2] = m[3] * m[7] - m[4] * m[6];
            c[3] = m[2] * m[7] - m[1] * m[8];
            c[4] = m[0] * m[8] - m[2] * m[6];
            c[5] = m[1] * m[6] - m[0] * m[7];
            c[6] = m[1] * m[5] - m[2] * m[4];
            c[7] = m[2] * m[3] - m[0] * m[5];
            c[8] = m[0] * m[4] - m[1] * m[3];
            det = 100'(m[0]) * 100'(c[0]) + 100'(m[1]) * 100'(c[1])
                + 100'(m[2]) * 100'(c[2]);
            dneg = det < 0;
            dmag = '0;
            dmag[99:0] = dneg ? -det : det;
            lim = 132'(threshold) << 32;
            res.saturated = 0;
            // small determinant: pass the block through
            if (dmag <= lim)
            begin
                res.r = b.e;
                res.singular = 1;
                return res;
            end
            res.singular = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    cf = c[3 * j + i];
                    cm = cf < 0 ? -cf : cf;
                    num = 132'(cm) << 32;
                    q = (2 * num + dmag) / (2 * dmag);
                    neg = (cf < 0) != dneg;
                    if (q == 0)
                        res.r[3 * i + j] = '0;
                    else if (!neg)
                    begin
                        if (q > 132'h7FFF_FFFF)
                        begin
                            res.r[3 * i + j] = inv3_pkg::SAT_POS;
                            res.saturated = 1;
                        end
                        else
                            res.r[3 * i + j] = q[31:0];
                    end
                    else
                    begin
                        if (q > 132'h8000_0000)
                        begin
                            res.r[3 * i + j] = inv3_pkg::SAT_NEG;
                            res.saturated = 1;
                        end
                        else
                            res.r[3 * i + j] = -q[31:0];
                    end
                end
            return res;
        endfunction

        function void note_block(blk_t b);
            pending.push_back(invert(b));
        endfunction

        function void check_result(inv_res_t act);
            inv_res_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result word with no block outstanding");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            n_checked++;
            if (exp_r.singular) n_singular++;
            if (exp_r.saturated) n_saturated++;
            for (int k = 0; k < inv3_pkg::N_ENT; k++)
                if (act.r[k] !== exp_r.r[k])
                begin
                    $error("r%0d%0d: expected %h, actual %h", k / 3, k % 3,
                           exp_r.r[k], act.r[k]);
                    errors++;
                end
            if (act.singular !== exp_r.singular)
            begin
                $error("singular: expected %b, actual %b", exp_r.singular, act.singular);
                errors++;
            end
            if (act.saturated !== exp_r.saturated)
            begin
                $error("saturated: expected %b, actual %b", exp_r.saturated, act.saturated);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = inv3_pkg::PIPE_DEPTH + 16;

    logic              clk, rst_n;
    logic              in_valid, in_stall, out_valid, out_stall;
    inv3_pkg::data_t   m_in [inv3_pkg::N_ENT];
    inv3_pkg::data_t   r_out [inv3_pkg::N_ENT];
    logic              singular, saturated;
    logic              cfg_valid, cfg_ready;
    logic [inv3_pkg::THR_W-1:0] thr_reg;
    bit                free_flow;
    int                idle_cycles;

    inverse_scoreboard sb;

    inverse_3x3_block_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .m00(m_in[0]), .m01(m_in[1]), .m02(m_in[2]),
        .m10(m_in[3]), .m11(m_in[4]), .m12(m_in[5]),
        .m20(m_in[6]), .m21(m_in[7]), .m22(m_in[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .r00(r_out[0]), .r01(r_out[1]), .r02(r_out[2]),
        .r10(r_out[3]), .r11(r_out[4]), .r12(r_out[5]),
        .r20(r_out[6]), .r21(r_out[7]), .r22(r_out[8]),
        .singular(singular), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .singular_threshold(thr_reg)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (free_flow || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random Q16.16 entry of a chosen flavor
    function automatic inv3_pkg::data_t pick_entry();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return inv3_pkg::data_t'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
        if (r < 70) return inv3_pkg::data_t'($urandom);
        if (r < 78) return '0;
        if (r < 84) return 32'h7FFF_FFFF;
        if (r < 90) return 32'h8000_0000;
        if (r < 95) return inv3_pkg::data_t'($signed($urandom_range(0, 8)) - 4);
        return inv3_pkg::data_t'(($signed($urandom_range(0, 8)) - 4) <<< 16);
    endfunction

    function automatic blk_t random_block();
        blk_t b;
        int   kind, src, dst;
        for (int k = 0; k < inv3_pkg::N_ENT; k++)
            b.e[k] = pick_entry();
        kind = $urandom_range(0, 9);
        // block with a random diagonal of magnitude 1.0 to 128.0
        if (kind < 4)
            for (int k = 0; k < 3; k++)
                b.e[4 * k] = inv3_pkg::data_t'($signed($urandom_range(32'h10000, 32'h800000))
                             * ($urandom_range(0, 1) ? 1 : -1));
        // singular by repeated row
        else if (kind == 4)
        begin
            src = $urandom_range(0, 2);
            dst = (src + $urandom_range(1, 2)) % 3;
            for (int k = 0; k < 3; k++)
                b.e[3 * dst + k] = b.e[3 * src + k];
        end
        // tiny diagonal: huge inverse, clipping
        else if (kind == 5)
        begin
            for (int k = 0; k < inv3_pkg::N_ENT; k++)
                b.e[k] = '0;
            for (int k = 0; k < 3; k++)
                b.e[4 * k] = inv3_pkg::data_t'($signed($urandom_range(1, 300))
                             * ($urandom_range(0, 1) ? 1 : -1));
        end
        return b;
    endfunction

    function automatic blk_t diag_block(inv3_pkg::data_t a, inv3_pkg::data_t d,
                                        inv3_pkg::data_t e);
        blk_t b;
        for (int k = 0; k < inv3_pkg::N_ENT; k++)
            b.e[k] = '0;
        b.e[0] = a;
        b.e[4] = d;
        b.e[8] = e;
        return b;
    endfunction

    function automatic blk_t fill_block(inv3_pkg::data_t v);
        blk_t b;
        for (int k = 0; k < inv3_pkg::N_ENT; k++)
            b.e[k] = v;
        return b;
    endfunction

    // drive one block word and hold it until accepted
    task automatic push_block(blk_t b);
        int g;
        @(negedge clk);
        in_valid <= 1;
        for (int k = 0; k < inv3_pkg::N_ENT; k++)
            m_in[k] <= b.e[k];
        do @(posedge clk); while (in_stall);
        sb.note_block(b);
        g = pick_gap();
        if (g > 0)
        begin
            @(negedge clk);
            in_valid <= 0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    // write the threshold once the pipe has drained
    task automatic write_threshold(logic [inv3_pkg::THR_W-1:0] v);
        @(negedge clk);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1;
        thr_reg <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.threshold = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 100 == 0) free_flow = ($urandom_range(0, 3) == 0);
            push_block(random_block());
        end
        free_flow = 0;
    endtask

    // output stall pattern
    initial
    begin
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                @(negedge clk);
                out_stall <= 0;
                repeat ($urandom_range(30, 150)) @(negedge clk);
            end
            else
            begin
                @(negedge clk);
                out_stall <= 1;
                repeat (pick_gap()) @(negedge clk);
                @(negedge clk);
                out_stall <= 0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        inv_res_t act;
        if (rst_n && out_valid && !out_stall)
        begin
            for (int k = 0; k < inv3_pkg::N_ENT; k++)
                act.r[k] = r_out[k];
            act.singular = singular;
            act.saturated = saturated;
            sb.check_result(act);
        end
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d blocks outstanding", sb.pending.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        blk_t b;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        cfg_valid = 0;
        thr_reg = '0;
        free_flow = 0;
        idle_cycles = 0;
        for (int k = 0; k < inv3_pkg::N_ENT; k++)
            m_in[k] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: zero threshold, only an exact zero determinant is singular
        push_block(diag_block(32'h10000, 32'h10000, 32'h10000));
        push_block(diag_block(-32'sh10000, -32'sh10000, -32'sh10000));
        push_block(fill_block('0));
        push_block(fill_block(32'h7FFF_FFFF));
        push_block(fill_block(32'h8000_0000));
        push_block(diag_block(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        push_block(diag_block(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        push_block(diag_block(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        push_block(diag_block(1, 1, 1));
        push_block(diag_block(-1, 1, 1));
        push_block(diag_block(32'h30000, 32'h30000, -32'sh30000));
        push_block(diag_block(32'h20000, 32'h20000, 32'h20000));
        push_block(diag_block(32'h10000, 32'h10000, 0));
        b = fill_block(32'h10000);
        b.e[0] = 32'h20000;
        b.e[4] = 32'h30000;
        push_block(b);
        b = fill_block(32'h8000_0000);
        b.e[1] = 32'h7FFF_FFFF;
        b.e[5] = 32'h7FFF_FFFF;
        b.e[6] = 32'h7FFF_FFFF;
        push_block(b);
        b = fill_block(32'hFFFF_FFFF);
        b.e[0] = 32'h5555_5555;
        b.e[4] = 32'hAAAA_AAAA;
        push_block(b);
        random_phase(250);

        // largest threshold: nearly everything passes through
        write_threshold({inv3_pkg::THR_W{1'b1}});
        push_block(diag_block(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        push_block(diag_block(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        random_phase(150);

        // unity threshold: det of the unit block sits right at the limit
        write_threshold(31'h10000);
        push_block(diag_block(32'h10000, 32'h10000, 32'h10000));
        push_block(diag_block(32'h10000, 32'h10000, 32'h10001));
        push_block(diag_block(-32'sh10000, 32'h10000, 32'h10000));
        random_phase(200);

        // smallest nonzero threshold
        write_threshold(31'h1);
        random_phase(200);

        write_threshold(31'($urandom));
        random_phase(150);

        write_threshold('0);
        random_phase(50);

        @(negedge clk);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d inverse words: %0d singular pass-throughs, %0d clipped",
                 sb.n_checked, sb.n_singular, sb.n_saturated);
        $display("six threshold settings from zero to full scale, random gaps and stalls");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
